[design/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg: shared constants and types for the p-code stack machine
// Opcodes, operator numbers, error codes and address widths.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int StackDepth = 4096;
  localparam int MaxLevel   = 3;
  localparam int CodeDepth  = 2048;
  localparam int SaW        = $clog2(StackDepth);   // store address bits
  localparam int PcW        = $clog2(CodeDepth);
  localparam int TopW       = SaW + 1;              // signed top pointer

  localparam logic [2:0] OpLit = 3'd0;
  localparam logic [2:0] OpOpr = 3'd1;
  localparam logic [2:0] OpLod = 3'd2;
  localparam logic [2:0] OpSto = 3'd3;
  localparam logic [2:0] OpCal = 3'd4;
  localparam logic [2:0] OpInt = 3'd5;
  localparam logic [2:0] OpJmp = 3'd6;
  localparam logic [2:0] OpJpc = 3'd7;

  localparam logic [10:0] OprRet = 11'd0;
  localparam logic [10:0] OprNeg = 11'd1;
  localparam logic [10:0] OprAdd = 11'd2;
  localparam logic [10:0] OprSub = 11'd3;
  localparam logic [10:0] OprMul = 11'd4;
  localparam logic [10:0] OprDiv = 11'd5;
  localparam logic [10:0] OprOdd = 11'd6;
  localparam logic [10:0] OprEq  = 11'd8;
  localparam logic [10:0] OprNe  = 11'd9;
  localparam logic [10:0] OprLt  = 11'd10;
  localparam logic [10:0] OprGe  = 11'd11;
  localparam logic [10:0] OprGt  = 11'd12;
  localparam logic [10:0] OprLe  = 11'd13;

  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrRange = 2'd1;
  localparam logic [1:0] ErrDiv0  = 2'd2;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

[design/psm_div.sv]
// ----------------------------------------------------------------------------
// psm_div: 32-bit signed truncating divider
// Restoring, one quotient bit per cycle on magnitudes; sign fixed at the end.
// ----------------------------------------------------------------------------
module psm_div
  import psm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shifted = {rem_q[30:0], quo_q[31]};
    trial   = {1'b0, shifted} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend[31] ? 32'(0 - req_i.dividend) : req_i.dividend;
      den_d  = req_i.divisor[31] ? 32'(0 - req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[31] ^ req_i.divisor[31];
      busy_d = 1'b1;
      cnt_d  = 6'd32;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 32'(0 - quo_q) : quo_q;

endmodule

[design/pcode_stack_machine_step_top.sv]
// ----------------------------------------------------------------------------
// pcode_stack_machine_step_top: PL/0 p-code instruction step engine
// Executes one instruction per input word against a 4096-word stack store.
// ----------------------------------------------------------------------------
// Steps: accept, walk static links for LOD/STO/CAL (one link read per level),
//   read operands, execute, multiply or divide, write results (CAL writes three
//   words), read the new top, output. One instruction at a time; a result held
//   by m_axis_tready stalls the next one at its output step.
// Reset: pc 0, frame base 0, top -1; a clearing pass writes zero to all 4096
//   entries before s_axis_tready rises.
module pcode_stack_machine_step_top
  import psm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] opcode, [4:3] level, [15:5] operand_addr
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] next_pc, [42:11] top_value, [55:43] top_index, [56] halted,
  // [58:57] error
  output logic [63:0] m_axis_tdata
);

  localparam logic [3:0] StClr  = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StWalk = 4'd2;  // issue link read
  localparam logic [3:0] StWlkW = 4'd3;  // link data arrives
  localparam logic [3:0] StRd1  = 4'd4;  // operand reads
  localparam logic [3:0] StRd2  = 4'd5;
  localparam logic [3:0] StRdW  = 4'd6;
  localparam logic [3:0] StExec = 4'd7;
  localparam logic [3:0] StMul  = 4'd8;
  localparam logic [3:0] StDiv  = 4'd9;
  localparam logic [3:0] StWr   = 4'd10; // sequential writes
  localparam logic [3:0] StTop  = 4'd11; // read new top
  localparam logic [3:0] StTopW = 4'd12;
  localparam logic [3:0] StOut  = 4'd13;

  logic [31:0] mem [StackDepth];
  logic        mem_we;
  logic [SaW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  logic [3:0]      st_q, st_d;
  logic [SaW:0]    clr_q, clr_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic [SaW-1:0]  fb_q, fb_d;
  logic [TopW-1:0] top_q, top_d;
  logic [2:0]  op_q, op_d;
  logic [1:0]  lv_q, lv_d;
  logic [10:0] a_q, a_d;
  logic [SaW-1:0] cur_q, cur_d;
  logic [31:0] x_q, x_d, y_q, y_d, r_q, r_d;
  logic [1:0]  wn_q, wn_d;       // writes left
  logic [1:0]  err_q, err_d;
  logic [TopW-1:0] nt_q, nt_d;
  logic [PcW-1:0]  np_q, np_d;
  logic [SaW-1:0]  nb_q, nb_d;
  logic [31:0] mul_q;
  logic        ovalid_q, ovalid_d;
  logic [63:0] odata_q, odata_d;
  div_req_t    dreq;
  logic        ddone;
  logic [31:0] dquot;

  psm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (dquot)
  );

  // signed arithmetic on a widened top pointer
  logic signed [TopW+1:0] ts, tp1, tm1, tp3, tpa, fba;
  logic signed [31:0] sx, sy;
  logic [PcW-1:0] pinc;

  function automatic logic in_rng(logic signed [TopW+1:0] v);
    return v >= 0 && v < StackDepth;
  endfunction

  always_comb begin
    ts   = (TopW+2)'(signed'(top_q));
    tp1  = ts + (TopW+2)'(1);
    tm1  = ts - (TopW+2)'(1);
    tp3  = ts + (TopW+2)'(3);
    tpa  = ts + (TopW+2)'(a_q);
    fba  = (TopW+2)'(cur_q) + (TopW+2)'(a_q);
    sx   = x_q;
    sy   = y_q;
    pinc = pc_q + 1'b1;
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; pc_d = pc_q; fb_d = fb_q; top_d = top_q;
    op_d = op_q; lv_d = lv_q; a_d = a_q; cur_d = cur_q; x_d = x_q; y_d = y_q;
    r_d = r_q; wn_d = wn_q; err_d = err_q; nt_d = nt_q; np_d = np_q;
    nb_d = nb_q; ovalid_d = ovalid_q; odata_d = odata_q;
    // idle reads keep the top word on the read port
    mem_we = 1'b0; mem_addr = top_q[SaW-1:0]; mem_wdata = '0;
    dreq = '{start: 1'b0, dividend: x_q, divisor: y_q};
    s_axis_tready = 1'b0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (st_q)
      StClr: begin
        mem_we = 1'b1;
        mem_addr = clr_q[SaW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (SaW+1)'(StackDepth - 1)) st_d = StIdle;
      end
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d = s_axis_tdata[2:0];
          lv_d = s_axis_tdata[4:3];
          a_d  = s_axis_tdata[15:5];
          cur_d = fb_q;
          err_d = ErrNone;
          nt_d = top_q; np_d = pinc; nb_d = fb_q;
          st_d = (s_axis_tdata[2:0] == OpLod || s_axis_tdata[2:0] == OpSto ||
                  s_axis_tdata[2:0] == OpCal) ? StWalk : StRd1;
        end
      end
      StWalk: begin
        if (lv_q == 2'd0) st_d = StRd1;
        else begin
          mem_addr = cur_q;
          st_d = StWlkW;
        end
      end
      StWlkW: begin
        if (mem_rdata >= 32'(StackDepth)) begin
          err_d = ErrRange; st_d = StTop;
        end else begin
          cur_d = mem_rdata[SaW-1:0];
          lv_d = lv_q - 2'd1;
          st_d = StWalk;
        end
      end
      StRd1: begin
        // first read: operand y (top) or frame-relative word
        st_d = StRd2;
        case (op_q)
          OpOpr: begin
            if (a_q == OprRet) begin
              mem_addr = SaW'(fb_q + 2'd2);  // return pc at b+2
            end else mem_addr = top_q[SaW-1:0];
          end
          OpLod:   mem_addr = fba[SaW-1:0];
          default: mem_addr = top_q[SaW-1:0];
        endcase
      end
      StRd2: begin
        st_d = StRdW;
        case (op_q)
          OpOpr: mem_addr = (a_q == OprRet) ? SaW'(fb_q + 2'd1)
                                            : tm1[SaW-1:0];
          default: mem_addr = top_q[SaW-1:0];
        endcase
        // data from first read arrives now
        y_d = mem_rdata;
      end
      StRdW: begin
        x_d = mem_rdata;
        st_d = StExec;
      end
      StExec: begin
        st_d = StTop;
        wn_d = 2'd0;
        case (op_q)
          OpLit: begin
            if (!in_rng(tp1)) err_d = ErrRange;
            else begin
              nt_d = tp1[TopW-1:0]; r_d = 32'(a_q); wn_d = 2'd1; st_d = StWr;
            end
          end
          OpOpr: begin
            if (a_q == OprRet) begin
              // y = word b+2 (return pc), x = word b+1 (saved base)
              if (!in_rng((TopW+2)'(fb_q) + (TopW+2)'(2)) ||
                  !in_rng((TopW+2)'(fb_q) + (TopW+2)'(1)))
                err_d = ErrRange;
              else if (x_q >= 32'(StackDepth)) err_d = ErrRange;
              else begin
                nt_d = TopW'((TopW+2)'(fb_q) - 1);
                np_d = y_q[PcW-1:0];
                nb_d = x_q[SaW-1:0];
              end
            end else if (a_q == OprNeg || a_q == OprOdd) begin
              if (!in_rng(ts)) err_d = ErrRange;
              else begin
                r_d = (a_q == OprNeg) ? 32'(0 - y_q) : {31'd0, y_q[0]};
                wn_d = 2'd1; st_d = StWr;
              end
            end else if ((a_q >= OprAdd && a_q <= OprDiv) ||
                         (a_q >= OprEq && a_q <= OprLe)) begin
              if (!in_rng(ts) || !in_rng(tm1)) err_d = ErrRange;
              else begin
                nt_d = tm1[TopW-1:0];
                wn_d = 2'd1; st_d = StWr;
                case (a_q)
                  OprAdd: r_d = x_q + y_q;
                  OprSub: r_d = x_q - y_q;
                  OprMul: st_d = StMul;
                  OprDiv: begin
                    if (y_q == '0) begin
                      err_d = ErrDiv0; st_d = StTop;
                    end else begin
                      dreq.start = 1'b1; st_d = StDiv;
                    end
                  end
                  OprEq: r_d = {31'd0, sx == sy};
                  OprNe: r_d = {31'd0, sx != sy};
                  OprLt: r_d = {31'd0, sx < sy};
                  OprGe: r_d = {31'd0, sx >= sy};
                  OprGt: r_d = {31'd0, sx > sy};
                  default: r_d = {31'd0, sx <= sy};
                endcase
              end
            end
          end
          OpLod: begin
            if (!in_rng(tp1) || !in_rng(fba)) err_d = ErrRange;
            else begin
              nt_d = tp1[TopW-1:0]; r_d = y_q; wn_d = 2'd1; st_d = StWr;
            end
          end
          OpSto: begin
            if (!in_rng(ts) || !in_rng(fba)) err_d = ErrRange;
            else begin
              nt_d = tm1[TopW-1:0]; r_d = y_q; wn_d = 2'd1; st_d = StWr;
            end
          end
          OpCal: begin
            if (!in_rng(tp1) || !in_rng(tp3)) err_d = ErrRange;
            else begin
              nb_d = tp1[SaW-1:0]; np_d = a_q[PcW-1:0];
              wn_d = 2'd3; st_d = StWr;
            end
          end
          OpInt: begin
            if (tpa > StackDepth - 1) err_d = ErrRange;
            else nt_d = tpa[TopW-1:0];
          end
          OpJmp: np_d = a_q[PcW-1:0];
          default: begin
            if (!in_rng(ts)) err_d = ErrRange;
            else begin
              if (y_q != '0) np_d = a_q[PcW-1:0];
              nt_d = tm1[TopW-1:0];
            end
          end
        endcase
      end
      StMul: begin
        r_d = mul_q;
        st_d = StWr;
      end
      StDiv: begin
        if (ddone) begin
          r_d = dquot; st_d = StWr;
        end
      end
      StWr: begin
        mem_we = 1'b1;
        mem_wdata = r_q;
        wn_d = wn_q - 2'd1;
        case (op_q)
          OpLit, OpLod: mem_addr = tp1[SaW-1:0];
          OpOpr: mem_addr = (a_q == OprNeg || a_q == OprOdd) ? top_q[SaW-1:0]
                                                            : tm1[SaW-1:0];
          OpSto: mem_addr = fba[SaW-1:0];
          default: begin
            // CAL frame: static link, dynamic link, return address
            case (wn_q)
              2'd3: begin mem_addr = tp1[SaW-1:0]; mem_wdata = 32'(cur_q); end
              2'd2: begin mem_addr = SaW'(tp1 + 1); mem_wdata = 32'(fb_q); end
              default: begin
                mem_addr = tp3[SaW-1:0]; mem_wdata = 32'(pinc);
              end
            endcase
          end
        endcase
        if (wn_q == 2'd1) st_d = StTop;
      end
      StTop: begin
        if (err_q == ErrNone) begin
          top_d = nt_q; pc_d = np_q; fb_d = nb_q;
        end
        mem_addr = (err_q == ErrNone) ? nt_q[SaW-1:0] : top_q[SaW-1:0];
        st_d = StTopW;
      end
      StTopW: begin
        st_d = StOut;
      end
      default: begin // StOut
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d = {5'd0, err_q, pc_q == '0, top_q,
                     top_q[TopW-1] ? 32'd0 : mem_rdata, pc_q};
          st_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; pc_q <= '0; fb_q <= '0;
      top_q <= '1; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; pc_q <= pc_d; fb_q <= fb_d;
      top_q <= top_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; lv_q <= lv_d; a_q <= a_d; cur_q <= cur_d;
    x_q <= x_d; y_q <= y_d; r_q <= r_d; wn_q <= wn_d; err_q <= err_d;
    nt_q <= nt_d; np_q <= np_d; nb_q <= nb_d;
    odata_q <= odata_d;
    mul_q <= x_q * y_q;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StTop) |=> (pc_q == $past(pc_q))) else $error("pc moved");
  a_no_err_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && st_q == StWr) |-> (err_q == ErrNone)) else $error("faulted write");
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!top_q[TopW-1]) |-> (top_q < TopW'(StackDepth))) else $error("top out");

endmodule

[tb/psm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_checker: stack machine step predictor and result scoreboard
// Watches both stream channels, steps its own copy of the machine for every
// accepted instruction word and compares each result word field by field.
// ----------------------------------------------------------------------------
module psm_checker
  import psm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  error;
    logic        halted;
    logic [12:0] top_index;
    logic [31:0] top_value;
    logic [10:0] next_pc;
  } step_res_t;

  logic [31:0] mem_q [StackDepth];
  logic [10:0] pc_q;
  int          base_q;
  int          top_q;
  step_res_t   expected_q[$];

  function automatic logic in_range(longint idx);
    return idx >= 0 && idx < StackDepth;
  endfunction

  // static-link walk; returns 0 on a bad link
  function automatic logic walk_links(logic [1:0] lv, output int fb);
    int cur;
    cur = base_q;
    fb  = 0;
    for (int k = 0; k < lv; k++) begin
      if (!in_range(cur)) return 0;
      if (mem_q[cur] >= StackDepth) return 0;
      cur = int'(mem_q[cur]);
    end
    fb = cur;
    return 1;
  endfunction

  function automatic step_res_t exec_instr(logic [15:0] w);
    logic [2:0]  op;
    logic [1:0]  lv;
    logic [10:0] a;
    int          t, b, fb;
    logic [10:0] p;
    logic [1:0]  err;
    logic [31:0] x, y, r;
    step_res_t   res;
    op  = w[2:0];
    lv  = w[4:3];
    a   = w[15:5];
    t   = top_q;
    b   = base_q;
    p   = pc_q + 11'd1;
    err = ErrNone;
    r   = '0;
    case (op)
      OpLit: begin
        if (!in_range(t + 1)) err = ErrRange;
        else begin
          t = t + 1;
          mem_q[t] = 32'(a);
        end
      end
      OpOpr: begin
        if (a == OprRet) begin
          if (!in_range(b + 1) || !in_range(b + 2) ||
              mem_q[b + 1] >= StackDepth)
            err = ErrRange;
          else begin
            t = b - 1;
            p = mem_q[b + 2][10:0];
            b = int'(mem_q[b + 1]);
          end
        end else if (a == OprNeg || a == OprOdd) begin
          if (!in_range(t)) err = ErrRange;
          else if (a == OprNeg) mem_q[t] = -mem_q[t];
          else mem_q[t] = {31'd0, mem_q[t][0]};
        end else if ((a >= OprAdd && a <= OprDiv) ||
                     (a >= OprEq && a <= OprLe)) begin
          if (!in_range(t) || !in_range(t - 1)) err = ErrRange;
          else begin
            x = mem_q[t - 1];
            y = mem_q[t];
            case (a)
              OprAdd: r = x + y;
              OprSub: r = x - y;
              OprMul: r = x * y;
              OprDiv: begin
                // 64-bit quotient so minimum over minus one wraps cleanly
                if (y == 0) err = ErrDiv0;
                else r = 32'(longint'($signed(x)) / longint'($signed(y)));
              end
              OprEq:  r = 32'($signed(x) == $signed(y));
              OprNe:  r = 32'($signed(x) != $signed(y));
              OprLt:  r = 32'($signed(x) < $signed(y));
              OprGe:  r = 32'($signed(x) >= $signed(y));
              OprGt:  r = 32'($signed(x) > $signed(y));
              default: r = 32'($signed(x) <= $signed(y));
            endcase
            if (err == ErrNone) begin
              t = t - 1;
              mem_q[t] = r;
            end
          end
        end
      end
      OpLod: begin
        if (!walk_links(lv, fb) || !in_range(t + 1) || !in_range(fb + int'(a)))
          err = ErrRange;
        else begin
          mem_q[t + 1] = mem_q[fb + int'(a)];
          t = t + 1;
        end
      end
      OpSto: begin
        if (!walk_links(lv, fb) || !in_range(t) || !in_range(fb + int'(a)))
          err = ErrRange;
        else begin
          mem_q[fb + int'(a)] = mem_q[t];
          t = t - 1;
        end
      end
      OpCal: begin
        if (!walk_links(lv, fb) || !in_range(t + 1) || !in_range(t + 3))
          err = ErrRange;
        else begin
          mem_q[t + 1] = 32'(fb);
          mem_q[t + 2] = 32'(b);
          mem_q[t + 3] = 32'(p);
          b = t + 1;
          p = a;
        end
      end
      OpInt: begin
        if (t + int'(a) > StackDepth - 1) err = ErrRange;
        else t = t + int'(a);
      end
      OpJmp: p = a;
      default: begin
        if (!in_range(t)) err = ErrRange;
        else begin
          if (mem_q[t] != 0) p = a;
          t = t - 1;
        end
      end
    endcase
    if (err == ErrNone) begin
      top_q  = t;
      base_q = b;
      pc_q   = p;
    end
    res.next_pc   = pc_q;
    res.top_value = in_range(top_q) ? mem_q[top_q] : 32'd0;
    res.top_index = 13'(top_q);
    res.halted    = (pc_q == 0);
    res.error     = err;
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    step_res_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < StackDepth; i++) mem_q[i] = '0;
      pc_q       = '0;
      base_q     = 0;
      top_q      = -1;
      fail_cnt_o <= 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = step_res_t'(m_axis_tdata[58:0]);
        if (expected_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected result word %h", got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            if (fail_cnt_o < 10) begin
              $display("mismatch: exp pc=%0d val=%h idx=%0d halt=%b err=%0d",
                       want.next_pc, want.top_value, $signed(want.top_index),
                       want.halted, want.error);
              $display("          got pc=%0d val=%h idx=%0d halt=%b err=%0d",
                       got.next_pc, got.top_value, $signed(got.top_index),
                       got.halted, got.error);
            end
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(exec_instr(s_axis_tdata));
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stack machine step testbench
// Directed corner instructions, then random programs built around calls,
// returns and arithmetic, with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import psm_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [63:0] m_axis_tdata;
  int          fail_cnt, pending;
  logic        quiet_q, hold_q;

  pcode_stack_machine_step_top uut (.*);

  psm_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

  // long receiver hold-off, timed in cycles, while the sender keeps offering
  initial begin
    hold_q = 0;
    wait (rst_ni);
    repeat (12000) @(posedge clk_i);
    hold_q <= 1;
    repeat (400) @(posedge clk_i);
    hold_q <= 0;
  end

  // receiver: random stalls
  initial begin
    m_axis_tready = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_q) m_axis_tready <= 0;
      else if (quiet_q) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(99) >= 21);
    end
  end

  task automatic send_word(logic [2:0] op, logic [1:0] lv, logic [10:0] a);
    while (!quiet_q && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {a, lv, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_word();
    logic [10:0] a;
    logic [1:0]  lv;
    int          pick;
    pick = int'($urandom_range(99));
    a    = 11'($urandom_range(2047));
    lv   = 2'($urandom);
    if (pick < 20) send_word(OpLit, lv, ($urandom_range(1) != 0) ? a : 11'($urandom_range(9)));
    else if (pick < 45) send_word(OpOpr, 2'd0, 11'($urandom_range(15)));
    else if (pick < 58) send_word(OpLod, lv, 11'($urandom_range(6)));
    else if (pick < 68) send_word(OpSto, lv, 11'($urandom_range(6)));
    else if (pick < 76) send_word(OpCal, lv, a);
    else if (pick < 84) send_word(OpInt, 2'd0, 11'($urandom_range(5)));
    else if (pick < 88) send_word(OpJmp, lv, a);
    else if (pick < 94) send_word(OpJpc, lv, a);
    else send_word(3'($urandom), lv, a);   // raw noise
  endtask

  initial begin
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    quiet_q = 0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    // directed corners
    send_word(OpOpr, 2'd0, OprAdd);   // empty stack
    send_word(OpJpc, 2'd0, 11'd5);
    send_word(OpLit, 2'd3, 11'd2047);
    send_word(OpLit, 2'd0, 11'd0);
    send_word(OpOpr, 2'd0, OprDiv);   // divide by zero
    send_word(OpOpr, 2'd0, OprNeg);
    send_word(OpLit, 2'd0, 11'd1);
    send_word(OpOpr, 2'd0, OprSub);
    send_word(OpOpr, 2'd0, OprNeg);
    send_word(OpLit, 2'd0, 11'd1);
    send_word(OpOpr, 2'd0, OprMul);
    send_word(OpOpr, 2'd0, OprOdd);
    send_word(OpOpr, 2'd0, 11'd7);
    send_word(OpOpr, 2'd0, 11'd14);
    send_word(OpOpr, 2'd0, 11'd2047);
    send_word(OpInt, 2'd0, 11'd3);
    send_word(OpCal, 2'd3, 11'd100);
    send_word(OpLod, 2'd3, 11'd0);
    send_word(OpSto, 2'd2, 11'd2047);
    send_word(OpOpr, 2'd0, OprRet);
    send_word(OpJmp, 2'd0, 11'd2047);
    send_word(OpInt, 2'd0, 11'd2047);
    send_word(OpInt, 2'd0, 11'd2047);  // overflow
    send_word(OpJpc, 2'd1, 11'd0);
    // build minimum int and divide by minus one
    send_word(OpLit, 2'd0, 11'd1024);
    send_word(OpLit, 2'd0, 11'd1024);
    send_word(OpOpr, 2'd0, OprMul);
    send_word(OpLit, 2'd0, 11'd1024);
    send_word(OpOpr, 2'd0, OprMul);
    send_word(OpLit, 2'd0, 11'd2);
    send_word(OpOpr, 2'd0, OprMul);    // minimum int
    send_word(OpLit, 2'd0, 11'd0);
    send_word(OpLit, 2'd0, 11'd1);
    send_word(OpOpr, 2'd0, OprSub);    // -1
    send_word(OpOpr, 2'd0, OprDiv);
    for (int i = 0; i < 1900; i++) begin
      quiet_q <= (i >= 1000 && i < 1200);
      // keep the stack away from the ceiling most of the time
      if (i % 300 == 299) send_word(OpOpr, 2'd0, OprRet);
      random_word();
    end
    s_axis_tvalid <= 0;
    fork
      begin
        wait (pending == 0);
        repeat (100) @(posedge clk_i);
      end
      begin
        repeat (200000) @(posedge clk_i);
      end
    join_any
    if (pending == 0 && fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
design/psm_pkg.sv
design/psm_div.sv
design/pcode_stack_machine_step_top.sv
tb/psm_checker.sv
tb/tb.sv
